FILE: design/paravirt_clock_to_calendar_macros.svh
`ifndef PARAVIRT_CLOCK_TO_CALENDAR_MACROS_SVH
`define PARAVIRT_CLOCK_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PVC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PVC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pvc_pkg.sv
`default_nettype none

package pvc_pkg;

   localparam int SEC_W     = 35;          // Unix seconds, up to about 2.3e10
   localparam int CSR_ADDR_W = 3;

   // ceil(2^84 / 1e9): ((ns >> 9) * RECIP) >> 75 is ns / 1e9 for every 64-bit ns
   localparam logic [31:0] RECIP_LO = 32'hA09B_5A53;
   localparam logic [31:0] RECIP_HI = 32'h0044_B82F;

   localparam logic [SEC_W-1:0] SECS_PER_DAY   = SEC_W'(60 * 60 * 24);
   localparam logic [SEC_W-1:0] SECS_PER_HOUR  = SEC_W'(3600);
   localparam logic [SEC_W-1:0] SECS_PER_MIN   = SEC_W'(60);
   localparam logic [SEC_W-1:0] YEAR_SECS      = SEC_W'(365 * 60 * 60 * 24);
   localparam logic [SEC_W-1:0] LEAP_YEAR_SECS = SEC_W'(366 * 60 * 60 * 24);
   localparam logic [SEC_W-1:0] MAX_MONTH_SECS = SEC_W'(31 * 60 * 60 * 24);

   localparam int FIRST_YEAR = 1970;

   // month index, January is zero
   localparam logic [3:0] MON_FEB = 4'd1;
   localparam logic [3:0] MON_APR = 4'd3;
   localparam logic [3:0] MON_JUN = 4'd5;
   localparam logic [3:0] MON_SEP = 4'd8;
   localparam logic [3:0] MON_NOV = 4'd10;
   localparam logic [3:0] MON_DEC = 4'd11;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_REF_COUNTER       = 3'd0,
      REG_BASE_NANOSECONDS  = 3'd1,
      REG_SCALE_FACTOR      = 3'd2,
      REG_PRE_SHIFT         = 3'd3,
      REG_WALL_BASE_SECONDS = 3'd4
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM_LO,
      ST_SUM_BASE,
      ST_DIV_LL,
      ST_DIV_LH,
      ST_DIV_HL,
      ST_DIV_HH,
      ST_DIV_TOP,
      ST_WALL,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MIN,
      ST_DONE
   } state_type;

   function automatic logic [SEC_W-1:0] month_secs(input logic leap, input logic [3:0] mon);
      logic [SEC_W-1:0] days;
      case (mon) inside
         MON_FEB:                            days = leap ? SEC_W'(29) : SEC_W'(28);
         MON_APR, MON_JUN, MON_SEP, MON_NOV: days = SEC_W'(30);
         default:                            days = SEC_W'(31);
      endcase
      return days * SECS_PER_DAY;
   endfunction

endpackage

`default_nettype wire

FILE: design/paravirt_clock_to_calendar.sv
// Each item runs the year walk from FIRST_YEAR up to its year, then the month, day, hour
//   and minute walks, so later years take longer; years past LAST_YEAR end the walk.
// Throughput: one item at a time; req_tready is high only while the sequencer is idle,
//   so a new item is accepted only after the previous one has left the sequencer.
// A finished result waits in the output register; the next item may start meanwhile.
// Reset (synchronous, active high) clears the sequencer, the output valid and the config.
`default_nettype none

module paravirt_clock_to_calendar #(
   parameter int LAST_YEAR = 2255
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [63:0]                    req_tdata,  // counter_now[63:0]
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
   // second[37:32], out_of_range[38], zero[39]
   output logic [39:0]                         rsp_tdata,
   input  wire logic                           csr_wen,
   input  wire logic [pvc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [63:0]                    csr_wdata
);
   import pvc_pkg::*;
   `include "paravirt_clock_to_calendar_macros.svh"

   localparam int YEAR_W = $clog2(LAST_YEAR + 2);
   localparam logic [YEAR_W-1:0] LAST_YEAR_V  = YEAR_W'(LAST_YEAR);
   localparam logic [YEAR_W-1:0] FIRST_YEAR_V = YEAR_W'(FIRST_YEAR);
   localparam logic [11:0]       LAST_YEAR_OUT = 12'(LAST_YEAR);

   // configuration
   logic [63:0] ref_counter_ff;
   logic [63:0] base_ns_ff;
   logic [31:0] scale_ff;
   logic [5:0]  pre_shift_ff;
   logic [31:0] wall_base_ff;

   // sequencer and datapath
   state_type         state_ff, state_in;
   logic [63:0]       delta_ff, delta_in;
   logic [63:0]       prod_ff, prod_in;
   logic [31:0]       lohi_ff, lohi_in;
   logic [63:0]       ns_ff, ns_in;
   logic [63:0]       acc_ff, acc_in;
   logic [SEC_W-1:0]  secs_ff, secs_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [1:0]        c4_ff, c4_in;
   logic [6:0]        c100_ff, c100_in;
   logic [8:0]        c400_ff, c400_in;
   logic [3:0]        mon_ff, mon_in;
   logic [4:0]        day_ff, day_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        min_ff, min_in;
   logic              oor_ff, oor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [39:0]       rsp_data_ff, rsp_data_in;

   // shared subtractor
   logic [SEC_W-1:0]  sub_a, sub_b, sub_diff;
   logic              sub_borrow, sub_geq;
   logic              leap;
   logic [5:0]        left_amt;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic              req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign leap     = (c4_ff == 2'd0) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign left_amt = 6'(6'd0 - pre_shift_ff);

   // shared multiplier: counter scaling, then the reciprocal product for the divide by 1e9
   always_comb begin
      unique case (state_ff)
         ST_MUL_LO: begin
            mul_a = delta_ff[31:0];
            mul_b = scale_ff;
         end
         ST_MUL_HI: begin
            mul_a = delta_ff[63:32];
            mul_b = scale_ff;
         end
         ST_DIV_LL: begin
            mul_a = ns_ff[40:9];
            mul_b = RECIP_LO;
         end
         ST_DIV_LH: begin
            mul_a = ns_ff[40:9];
            mul_b = RECIP_HI;
         end
         ST_DIV_HL: begin
            mul_a = 32'(ns_ff[63:41]);
            mul_b = RECIP_LO;
         end
         default: begin
            mul_a = 32'(ns_ff[63:41]);
            mul_b = RECIP_HI;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      unique case (state_ff)
         ST_YEAR: begin
            sub_a = secs_ff;
            sub_b = leap ? LEAP_YEAR_SECS : YEAR_SECS;
         end
         ST_MONTH: begin
            sub_a = secs_ff;
            sub_b = month_secs(leap, mon_ff);
         end
         ST_DAY: begin
            sub_a = secs_ff;
            sub_b = SECS_PER_DAY;
         end
         ST_HOUR: begin
            sub_a = secs_ff;
            sub_b = SECS_PER_HOUR;
         end
         default: begin
            sub_a = secs_ff;
            sub_b = SECS_PER_MIN;
         end
      endcase
      {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
      sub_geq = !sub_borrow;
   end

   always_comb begin
      state_in     = state_ff;
      delta_in     = delta_ff;
      prod_in      = prod_ff;
      lohi_in      = lohi_ff;
      ns_in        = ns_ff;
      acc_in       = acc_ff;
      secs_in      = secs_ff;
      year_in      = year_ff;
      c4_in        = c4_ff;
      c100_in      = c100_ff;
      c400_in      = c400_ff;
      mon_in       = mon_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               delta_in = req_tdata - ref_counter_ff;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (pre_shift_ff[5]) begin
               delta_in = delta_ff << left_amt;
            end else begin
               delta_in = delta_ff >> pre_shift_ff[4:0];
            end
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            prod_in  = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            lohi_in  = prod_ff[63:32];
            prod_in  = mul_p;
            state_in = ST_SUM_LO;
         end
         ST_SUM_LO: begin
            ns_in    = prod_ff + 64'(lohi_ff);
            state_in = ST_SUM_BASE;
         end
         ST_SUM_BASE: begin
            ns_in    = ns_ff + base_ns_ff;
            state_in = ST_DIV_LL;
         end
         // divide by 1e9: sum the four partial products of (ns >> 9) and the
         // reciprocal, keeping only the bits above 64, then drop 11 more
         ST_DIV_LL: begin
            prod_in  = mul_p;
            state_in = ST_DIV_LH;
         end
         ST_DIV_LH: begin
            acc_in   = {32'd0, prod_ff[63:32]};
            prod_in  = mul_p;
            state_in = ST_DIV_HL;
         end
         ST_DIV_HL: begin
            acc_in   = acc_ff + prod_ff;
            prod_in  = mul_p;
            state_in = ST_DIV_HH;
         end
         ST_DIV_HH: begin
            acc_in   = acc_ff + prod_ff;
            prod_in  = mul_p;
            state_in = ST_DIV_TOP;
         end
         ST_DIV_TOP: begin
            acc_in   = prod_ff + {32'd0, acc_ff[63:32]};
            state_in = ST_WALL;
         end
         ST_WALL: begin
            secs_in  = acc_ff[SEC_W+10:11] + SEC_W'(wall_base_ff);
            year_in  = FIRST_YEAR_V;
            c4_in    = 2'(FIRST_YEAR % 4);
            c100_in  = 7'(FIRST_YEAR % 100);
            c400_in  = 9'(FIRST_YEAR % 400);
            oor_in   = 1'b0;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            if (year_ff > LAST_YEAR_V) begin
               oor_in   = 1'b1;
               state_in = ST_DONE;
            end else if (sub_geq) begin
               secs_in = sub_diff;
               year_in = year_ff + YEAR_W'(1);
               c4_in   = c4_ff + 2'd1;
               c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
            end else begin
               mon_in   = '0;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (sub_geq && (mon_ff != MON_DEC)) begin
               secs_in = sub_diff;
               mon_in  = mon_ff + 4'd1;
            end else begin
               day_in   = '0;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            if (sub_geq) begin
               secs_in = sub_diff;
               day_in  = day_ff + 5'd1;
            end else begin
               hour_in  = '0;
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            if (sub_geq) begin
               secs_in = sub_diff;
               hour_in = hour_ff + 5'd1;
            end else begin
               min_in   = '0;
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (sub_geq) begin
               secs_in = sub_diff;
               min_in  = min_ff + 6'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (oor_ff) begin
                  rsp_data_in = {1'b0, 1'b1, 6'd59, 6'd59, 5'd23, 5'd31, 4'd12,
                                 LAST_YEAR_OUT};
               end else begin
                  rsp_data_in = {1'b0, 1'b0, secs_ff[5:0], min_ff, hour_ff,
                                 day_ff + 5'd1, mon_ff + 4'd1, 12'(year_ff)};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      prod_ff     <= prod_in;
      lohi_ff     <= lohi_in;
      ns_ff       <= ns_in;
      acc_ff      <= acc_in;
      secs_ff     <= secs_in;
      year_ff     <= year_in;
      c4_ff       <= c4_in;
      c100_ff     <= c100_in;
      c400_ff     <= c400_in;
      mon_ff      <= mon_in;
      day_ff      <= day_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_counter_ff <= '0;
         base_ns_ff     <= '0;
         scale_ff       <= '0;
         pre_shift_ff   <= '0;
         wall_base_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_REF_COUNTER:       ref_counter_ff <= csr_wdata;
            REG_BASE_NANOSECONDS:  base_ns_ff     <= csr_wdata;
            REG_SCALE_FACTOR:      scale_ff       <= csr_wdata[31:0];
            REG_PRE_SHIFT:         pre_shift_ff   <= csr_wdata[5:0];
            REG_WALL_BASE_SECONDS: wall_base_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   `PVC_ASSERT_NEXT(a_accept_starts, req_fire, state_ff == ST_SHIFT, "accepted item did not start")
   `PVC_ASSERT_NOW(a_month_bound, state_ff == ST_MONTH, mon_ff <= MON_DEC, "month index past December")
   `PVC_ASSERT_NOW(a_day_bound, state_ff == ST_DAY, secs_ff < MAX_MONTH_SECS, "day walk starts past one month")
   `PVC_ASSERT_NOW(a_hour_bound, state_ff == ST_HOUR, secs_ff < SECS_PER_DAY, "hour walk starts past one day")
   `PVC_ASSERT_NOW(a_oor_year, rsp_valid_ff && rsp_data_ff[38], rsp_data_ff[11:0] == LAST_YEAR_OUT, "out of range result without last year")

endmodule

`default_nettype wire
